[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AST_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gac_pkg.sv]
package gac_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int OUT_W      = 16;
  localparam int DZ_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int N_STICK = 4;
  localparam int N_TRIG  = 2;
  localparam int N_AXES  = N_STICK + N_TRIG;

  // quotient bits produced by the serial divider per axis
  localparam int DIV_STEPS = 16;

  localparam int STICK_MAX = 32767;
  localparam int TRIG_MAX  = 65535;

  localparam int CENTER_RST   = 1800;
  localparam int STICK_LO_RST = 400;
  localparam int STICK_HI_RST = 3200;
  localparam int TRIG_LO_RST  = 1200;
  localparam int TRIG_HI_RST  = 2200;
  localparam int CDZ_RST      = 100;
  localparam int EDZ_RST      = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIBRATING = 2'd0,
    REG_CENTER_DZ   = 2'd1,
    REG_EDGE_DZ     = 2'd2
  } cfg_reg_t;

endpackage

[rtl/core/gac_if.sv]
interface gac_in_if #(parameter int ADC_BITS = gac_pkg::ADC_BITS_DEF);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] left_x_raw;
  logic [ADC_BITS-1:0] left_y_raw;
  logic [ADC_BITS-1:0] right_x_raw;
  logic [ADC_BITS-1:0] right_y_raw;
  logic [ADC_BITS-1:0] left_trigger_raw;
  logic [ADC_BITS-1:0] right_trigger_raw;

  modport source (
    output valid, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
           left_trigger_raw, right_trigger_raw,
    input  ready
  );
  modport sink (
    input  valid, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
           left_trigger_raw, right_trigger_raw,
    output ready
  );
endinterface

interface gac_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gac_pkg::OUT_W-1:0]   left_x_out;
  logic signed [gac_pkg::OUT_W-1:0]   left_y_out;
  logic signed [gac_pkg::OUT_W-1:0]   right_x_out;
  logic signed [gac_pkg::OUT_W-1:0]   right_y_out;
  logic        [gac_pkg::OUT_W-1:0]   left_trigger_out;
  logic        [gac_pkg::OUT_W-1:0]   right_trigger_out;

  modport source (
    output valid, left_x_out, left_y_out, right_x_out, right_y_out,
           left_trigger_out, right_trigger_out,
    input  ready
  );
  modport sink (
    input  valid, left_x_out, left_y_out, right_x_out, right_y_out,
           left_trigger_out, right_trigger_out,
    output ready
  );
endinterface

interface gac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gac_pkg::CFG_IDX_W-1:0]   index;
  logic [gac_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/gamepad_axis_calibrator.sv]
// Channel   Bus       Direction  Word
// config    cfg_bus   in         register index + write data, always ready
// samples   in_bus    in         six raw ADC axes
// results   out_bus   out        four stick and two trigger values
//
// A sample in calibration mode is absorbed in its accept cycle.
// A normal sample runs the six axes one after another: per axis the setup states
// PREP1, PREP2 and PREP3 and the write-back state, plus the shared bit-serial divider
// when the axis needs a divide; no new sample is accepted before the sixth axis is written back.
// Synchronous active-low reset restores the default calibration.
// The result register frees the engine: a new sample is taken while the last
// word still waits on out_bus; only a second finished word waits for it.
`include "assert_macros.svh"

module gamepad_axis_calibrator #(
  parameter int ADC_BITS = gac_pkg::ADC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gac_cfg_if.sink   cfg_bus,
  gac_in_if.sink    in_bus,
  gac_out_if.source out_bus
);
  import gac_pkg::*;

  localparam int W    = ADC_BITS;
  localparam int DW   = (W > DZ_W) ? W : DZ_W;
  localparam int SW   = DW + 3;
  localparam int AX_W = $clog2(N_AXES);
  localparam int BC_W = $clog2(DIV_STEPS);

  localparam logic [W-1:0] CTR_RST_V = W'(CENTER_RST);
  localparam logic [W-1:0] SLO_RST_V = W'(STICK_LO_RST);
  localparam logic [W-1:0] SHI_RST_V = W'(STICK_HI_RST);
  localparam logic [W-1:0] TLO_RST_V = W'(TRIG_LO_RST);
  localparam logic [W-1:0] THI_RST_V = W'(TRIG_HI_RST);

  localparam logic [OUT_W-1:0] STICK_MAX_V = OUT_W'(STICK_MAX);
  localparam logic [OUT_W-1:0] TRIG_MAX_V  = OUT_W'(TRIG_MAX);
  localparam logic [OUT_W-1:0] OUT_NEG_BAD = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [AX_W-1:0]  AX_LAST     = AX_W'(N_AXES - 1);
  localparam logic [BC_W-1:0]  BC_LAST     = BC_W'(DIV_STEPS - 1);

  typedef logic signed [SW-1:0] sval_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP1 = 7'b0000010,
    ST_PREP2 = 7'b0000100,
    ST_PREP3 = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  function automatic sval_t ext_w(input logic [W-1:0] x);
    return $signed({{(SW-W){1'b0}}, x});
  endfunction

  function automatic sval_t ext_dz(input logic [DZ_W-1:0] x);
    return $signed({{(SW-DZ_W){1'b0}}, x});
  endfunction

  // configuration and calibration store
  logic            cal_r, pend_r;
  logic [DZ_W-1:0] cdz_r, edz_r;
  logic [W-1:0]    ctr_r [N_STICK];
  logic [W-1:0]    slo_r [N_STICK];
  logic [W-1:0]    shi_r [N_STICK];
  logic [W-1:0]    tlo_r [N_TRIG];
  logic [W-1:0]    thi_r [N_TRIG];

  // engine
  state_t          st_r;
  logic [AX_W-1:0] ax_r;
  logic [BC_W-1:0] bc_r;
  logic [W-1:0]    raw_r [N_AXES];
  sval_t           cmd_r, cpd_r, lob_r, hib_r, rawv_r;
  logic            stk_r, below_r;
  sval_t           span_r, m_r;
  logic            zero_r, full_r, neg_r;
  logic            zk_r, fk_r;
  logic [W-1:0]    rem_r, dvs_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [OUT_W-1:0] res_r [N_AXES];

  // result register
  logic            out_valid_r;
  logic [OUT_W-1:0] ob_r [N_AXES];

  logic            in_acc, cfg_acc, out_free;
  logic [W-1:0]    in_raw [N_AXES];

  assign in_bus.ready  = (st_r == ST_IDLE);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign cfg_acc       = cfg_bus.valid;
  assign out_free      = !out_valid_r || out_bus.ready;

  assign in_raw[0] = in_bus.left_x_raw;
  assign in_raw[1] = in_bus.left_y_raw;
  assign in_raw[2] = in_bus.right_x_raw;
  assign in_raw[3] = in_bus.right_y_raw;
  assign in_raw[4] = in_bus.left_trigger_raw;
  assign in_raw[5] = in_bus.right_trigger_raw;

  assign out_bus.valid             = out_valid_r;
  assign out_bus.left_x_out        = $signed(ob_r[0]);
  assign out_bus.left_y_out        = $signed(ob_r[1]);
  assign out_bus.right_x_out       = $signed(ob_r[2]);
  assign out_bus.right_y_out       = $signed(ob_r[3]);
  assign out_bus.left_trigger_out  = ob_r[4];
  assign out_bus.right_trigger_out = ob_r[5];

  // ---------------------------------------------------------------- setup
  logic            p_stick;
  logic [1:0]      p_sidx;
  logic            p_tidx;
  sval_t           p_c, p_d, p_e, p_lo, p_hi, p_raw;

  always_comb begin
    p_stick = (ax_r < AX_W'(N_STICK));
    p_sidx  = ax_r[1:0];
    p_tidx  = ax_r[0];
    p_c     = ext_w(ctr_r[p_sidx]);
    p_d     = ext_dz(cdz_r);
    p_e     = ext_dz(edz_r);
    p_lo    = p_stick ? ext_w(slo_r[p_sidx]) : ext_w(tlo_r[p_tidx]);
    p_hi    = p_stick ? ext_w(shi_r[p_sidx]) : ext_w(thi_r[p_tidx]);
    p_raw   = ext_w(raw_r[ax_r]);
  end

  // second setup step: span, distance from the reference point, flags
  sval_t q_span, q_m;
  logic  q_zero, q_full, q_neg;

  always_comb begin
    if (stk_r) begin
      q_span = below_r ? (cmd_r - lob_r) : (hib_r - cpd_r);
      q_m    = below_r ? (cmd_r - rawv_r) : (rawv_r - cpd_r);
      q_zero = (rawv_r > cmd_r) && (rawv_r < cpd_r);
      q_full = 1'b0;
      q_neg  = below_r ^ ax_r[0];
    end else begin
      q_span = hib_r - lob_r;
      q_m    = hib_r - rawv_r;
      q_zero = (rawv_r >= hib_r);
      q_full = (rawv_r <= lob_r);
      q_neg  = 1'b0;
    end
  end

  // third step: classify and load the dividend (m*65534 for sticks so the
  // 16-bit quotient holds one extra bit, m*65535 for triggers)
  logic [W-1:0]            r_m;
  logic [W+DIV_STEPS-1:0]  r_dvd;
  logic                    r_span_le0, r_zero, r_full;

  always_comb begin
    r_m        = m_r[W-1:0];
    r_dvd      = stk_r ? ({r_m, {DIV_STEPS{1'b0}}} - {{(DIV_STEPS-1){1'b0}}, r_m, 1'b0})
                       : ({r_m, {DIV_STEPS{1'b0}}} - {{DIV_STEPS{1'b0}}, r_m});
    r_span_le0 = span_r[SW-1] || (span_r == '0);
    r_zero     = r_span_le0 || (!full_r && zero_r);
    r_full     = !r_zero && (full_r || (m_r >= span_r));
  end

  // divider step: restoring, one quotient bit a cycle
  logic [W:0]   d_shift, d_diff;
  logic         d_ge;

  always_comb begin
    d_shift = {rem_r, quo_r[DIV_STEPS-1]};
    d_ge    = (d_shift >= {1'b0, dvs_r});
    d_diff  = d_shift - {1'b0, dvs_r};
  end

  // write-back value
  logic [OUT_W-1:0] w_mag, w_val;

  always_comb begin
    if (zk_r) begin
      w_mag = '0;
    end else if (fk_r) begin
      w_mag = stk_r ? STICK_MAX_V : TRIG_MAX_V;
    end else begin
      w_mag = stk_r ? {1'b0, quo_r[DIV_STEPS-1:1]} : quo_r;
    end
    w_val = (stk_r && neg_r) ? (~w_mag + 1'b1) : w_mag;
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ax_r <= '0;
      bc_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc && !cal_r) begin
            st_r <= ST_PREP1;
            ax_r <= '0;
          end
        end
        ST_PREP1: st_r <= ST_PREP2;
        ST_PREP2: st_r <= ST_PREP3;
        ST_PREP3: begin
          bc_r <= '0;
          st_r <= (r_zero || r_full) ? ST_WB : ST_DIV;
        end
        ST_DIV: begin
          bc_r <= bc_r + 1'b1;
          if (bc_r == BC_LAST) begin
            st_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (ax_r == AX_LAST) begin
            st_r <= ST_DONE;
          end else begin
            ax_r <= ax_r + 1'b1;
            st_r <= ST_PREP1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc && !cal_r) begin
      for (int i = 0; i < N_AXES; i++) begin
        raw_r[i] <= in_raw[i];
      end
    end
    if (st_r == ST_PREP1) begin
      stk_r   <= p_stick;
      cmd_r   <= p_c - p_d;
      cpd_r   <= p_c + p_d;
      lob_r   <= p_lo + p_e;
      hib_r   <= p_hi - p_e;
      rawv_r  <= p_raw;
      below_r <= (p_raw < p_c);
    end
    if (st_r == ST_PREP2) begin
      span_r <= q_span;
      m_r    <= q_m;
      zero_r <= q_zero;
      full_r <= q_full;
      neg_r  <= q_neg;
    end
    if (st_r == ST_PREP3) begin
      zk_r  <= r_zero;
      fk_r  <= r_full;
      dvs_r <= span_r[W-1:0];
      rem_r <= r_dvd[W+DIV_STEPS-1:DIV_STEPS];
      quo_r <= r_dvd[DIV_STEPS-1:0];
    end
    if (st_r == ST_DIV) begin
      rem_r <= d_ge ? d_diff[W-1:0] : d_shift[W-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], d_ge};
    end
    if (st_r == ST_WB) begin
      res_r[ax_r] <= w_val;
    end
    if (st_r == ST_DONE && out_free) begin
      for (int i = 0; i < N_AXES; i++) begin
        ob_r[i] <= res_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- calibration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r  <= 1'b0;
      pend_r <= 1'b0;
      cdz_r  <= DZ_W'(CDZ_RST);
      edz_r  <= DZ_W'(EDZ_RST);
      for (int i = 0; i < N_STICK; i++) begin
        ctr_r[i] <= CTR_RST_V;
        slo_r[i] <= SLO_RST_V;
        shi_r[i] <= SHI_RST_V;
      end
      for (int i = 0; i < N_TRIG; i++) begin
        tlo_r[i] <= TLO_RST_V;
        thi_r[i] <= THI_RST_V;
      end
    end else begin
      if (in_acc && cal_r) begin
        if (pend_r) begin
          // first sample after arming sets every bound
          for (int i = 0; i < N_STICK; i++) begin
            ctr_r[i] <= in_raw[i];
            slo_r[i] <= in_raw[i];
            shi_r[i] <= in_raw[i];
          end
          for (int i = 0; i < N_TRIG; i++) begin
            tlo_r[i] <= in_raw[N_STICK+i];
            thi_r[i] <= in_raw[N_STICK+i];
          end
          pend_r <= 1'b0;
        end else begin
          for (int i = 0; i < N_STICK; i++) begin
            if (in_raw[i] < slo_r[i]) slo_r[i] <= in_raw[i];
            if (in_raw[i] > shi_r[i]) shi_r[i] <= in_raw[i];
          end
          for (int i = 0; i < N_TRIG; i++) begin
            if (in_raw[N_STICK+i] < tlo_r[i]) tlo_r[i] <= in_raw[N_STICK+i];
            if (in_raw[N_STICK+i] > thi_r[i]) thi_r[i] <= in_raw[N_STICK+i];
          end
        end
      end
      if (cfg_acc) begin
        unique case (cfg_reg_t'(cfg_bus.index))
          REG_CALIBRATING: begin
            cal_r <= cfg_bus.data[0];
            if (cfg_bus.data[0]) pend_r <= 1'b1;
          end
          REG_CENTER_DZ: cdz_r <= cfg_bus.data;
          REG_EDGE_DZ:   edz_r <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checks
  `AST_CHK(a_div_rem, (st_r == ST_DIV) |-> (rem_r < dvs_r), "divider remainder reached divisor")
  `AST_NEXT(a_cal_idle, in_acc && cal_r, st_r == ST_IDLE, "calibration sample started the engine")
  `AST_NEXT(a_capture, in_acc && cal_r && pend_r && !cfg_acc, !pend_r && (slo_r[0] == shi_r[0]), "capture did not set bounds")
  `AST_CHK(a_lx_sat, out_bus.valid |-> (out_bus.left_x_out != OUT_NEG_BAD), "left X below limit")
  `AST_CHK(a_ry_sat, out_bus.valid |-> (out_bus.right_y_out != OUT_NEG_BAD), "right Y below limit")

endmodule

[tb/gamepad_axis_calibrator_tb.sv]
`timescale 1ns / 100ps

module gamepad_axis_calibrator_tb;
  import gac_pkg::*;

  localparam int ADC_BITS       = ADC_BITS_DEF;
  localparam int ADC_MAX        = (1 << ADC_BITS) - 1;
  localparam int SETTLE_CYCLES  = 140;   // outlasts the longest sample
  localparam int LONG_HOLD      = 600;
  localparam int RANDOM_SAMPLES = 450;
  localparam int CALM_TAIL      = 70;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [N_AXES-1:0][ADC_BITS-1:0] sample_t;
  typedef logic [N_AXES-1:0][OUT_W-1:0]    axes_word_t;

  logic clk;
  logic rst_n;

  gac_cfg_if                       cfg_bus ();
  gac_in_if #(.ADC_BITS(ADC_BITS)) in_bus ();
  gac_out_if                       out_bus ();

  gamepad_axis_calibrator #(.ADC_BITS(ADC_BITS)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // calibration mirror
  logic [ADC_BITS-1:0] stick_mid [N_STICK];
  logic [ADC_BITS-1:0] stick_min [N_STICK];
  logic [ADC_BITS-1:0] stick_max [N_STICK];
  logic [ADC_BITS-1:0] trig_min  [N_TRIG];
  logic [ADC_BITS-1:0] trig_max  [N_TRIG];
  logic                cal_mode;
  logic                capture_armed;
  logic [DZ_W-1:0]     mid_dz;
  logic [DZ_W-1:0]     edge_dz;

  axes_word_t  expected_words [$];
  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_cycles  = 0;
  bit          idle_on      = 1'b1;

  string field_name [N_AXES] = '{"left_x_out", "left_y_out", "right_x_out", "right_y_out",
                                 "left_trigger_out", "right_trigger_out"};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void load_defaults();
    cal_mode      = 1'b0;
    capture_armed = 1'b0;
    mid_dz        = DZ_W'(CDZ_RST);
    edge_dz       = DZ_W'(EDZ_RST);
    for (int i = 0; i < N_STICK; i++) begin
      stick_mid[i] = ADC_BITS'(CENTER_RST);
      stick_min[i] = ADC_BITS'(STICK_LO_RST);
      stick_max[i] = ADC_BITS'(STICK_HI_RST);
    end
    for (int t = 0; t < N_TRIG; t++) begin
      trig_min[t] = ADC_BITS'(TRIG_LO_RST);
      trig_max[t] = ADC_BITS'(TRIG_HI_RST);
    end
  endfunction

  function automatic logic [OUT_W-1:0] stick_value(input int axis,
                                                   input logic [ADC_BITS-1:0] raw_in);
    longint raw, c, d, e, lo, hi, span, v;
    raw = raw_in;
    c   = stick_mid[axis];
    d   = mid_dz;
    e   = edge_dz;
    lo  = stick_min[axis];
    hi  = stick_max[axis];
    if (raw > c - d && raw < c + d) return '0;
    if (raw < c) begin
      span = (c - d) - (lo + e);
      if (span <= 0) return '0;
      v = (raw - (c - d)) * STICK_MAX / span;
    end else begin
      span = (hi - e) - (c + d);
      if (span <= 0) return '0;
      v = (raw - (c + d)) * STICK_MAX / span;
    end
    if (axis % 2 == 1) v = -v;   // Y axes inverted
    if (v > STICK_MAX) v = STICK_MAX;
    if (v < -STICK_MAX) v = -STICK_MAX;
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] trigger_value(input int t,
                                                     input logic [ADC_BITS-1:0] raw_in);
    longint raw, e, lo, hi, v;
    raw = raw_in;
    e   = edge_dz;
    lo  = trig_min[t];
    hi  = trig_max[t];
    lo  = lo + e;
    hi  = hi - e;
    if (hi - lo <= 0) return '0;
    if (raw <= lo) return OUT_W'(TRIG_MAX);
    if (raw >= hi) return '0;
    v = (hi - raw) * TRIG_MAX / (hi - lo);
    return v[OUT_W-1:0];
  endfunction

  function automatic void apply_sample(input sample_t s);
    axes_word_t w;
    if (cal_mode) begin
      for (int i = 0; i < N_STICK; i++) begin
        if (capture_armed) begin
          stick_mid[i] = s[i];
          stick_min[i] = s[i];
          stick_max[i] = s[i];
        end else begin
          if (s[i] < stick_min[i]) stick_min[i] = s[i];
          if (s[i] > stick_max[i]) stick_max[i] = s[i];
        end
      end
      for (int t = 0; t < N_TRIG; t++) begin
        if (capture_armed) begin
          trig_min[t] = s[N_STICK+t];
          trig_max[t] = s[N_STICK+t];
        end else begin
          if (s[N_STICK+t] < trig_min[t]) trig_min[t] = s[N_STICK+t];
          if (s[N_STICK+t] > trig_max[t]) trig_max[t] = s[N_STICK+t];
        end
      end
      capture_armed = 1'b0;
    end else begin
      for (int i = 0; i < N_STICK; i++) w[i] = stick_value(i, s[i]);
      for (int t = 0; t < N_TRIG; t++) w[N_STICK+t] = trigger_value(t, s[N_STICK+t]);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CALIBRATING: begin
        cal_mode = data[0];
        if (data[0]) capture_armed = 1'b1;
      end
      REG_CENTER_DZ: mid_dz = data;
      REG_EDGE_DZ:   edge_dz = data;
      default: ;
    endcase
  endfunction

  function automatic sample_t raw_sample(input int lx, input int ly, input int rx,
                                         input int ry, input int lt, input int rt);
    sample_t s;
    s[0] = ADC_BITS'(lx);
    s[1] = ADC_BITS'(ly);
    s[2] = ADC_BITS'(rx);
    s[3] = ADC_BITS'(ry);
    s[4] = ADC_BITS'(lt);
    s[5] = ADC_BITS'(rt);
    return s;
  endfunction

  function automatic logic [ADC_BITS-1:0] to_raw(input int v);
    if (v < 0) return '0;
    if (v > ADC_MAX) return '1;
    return v[ADC_BITS-1:0];
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_stick(input int axis);
    int c, v;
    c = stick_mid[axis];
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, ADC_MAX);
      1: v = c + int'($urandom_range(0, 800)) - 400;
      2: v = c + ($urandom_range(0, 1) ? int'(mid_dz) : -int'(mid_dz))
             + int'($urandom_range(0, 4)) - 2;
      3: v = ($urandom_range(0, 1) ? int'(stick_min[axis]) + int'(edge_dz)
                                   : int'(stick_max[axis]) - int'(edge_dz))
             + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 1) ? int'($urandom_range(0, 63))
                                        : int'($urandom_range(ADC_MAX - 63, ADC_MAX));
    endcase
    return to_raw(v);
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_trigger(input int t);
    int lo, hi, v;
    lo = int'(trig_min[t]) + int'(edge_dz);
    hi = int'(trig_max[t]) - int'(edge_dz);
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, ADC_MAX);
      1: v = lo + int'($urandom_range(0, 4)) - 2;
      2: v = hi + int'($urandom_range(0, 4)) - 2;
      default: v = int'(trig_min[t])
                   + int'($urandom_range(0, int'(trig_max[t]) - int'(trig_min[t])));
    endcase
    return to_raw(v);
  endfunction

  function automatic sample_t random_normal_sample();
    sample_t s;
    for (int i = 0; i < N_STICK; i++) s[i] = pick_stick(i);
    for (int t = 0; t < N_TRIG; t++) s[N_STICK+t] = pick_trigger(t);
    return s;
  endfunction

  // valid stays high on return; the next send or settle takes it over
  task automatic send_sample(input sample_t s);
    cfg_bus.valid <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.left_x_raw        <= s[0];
    in_bus.left_y_raw        <= s[1];
    in_bus.right_x_raw       <= s[2];
    in_bus.right_y_raw       <= s[3];
    in_bus.left_trigger_raw  <= s[4];
    in_bus.right_trigger_raw <= s[5];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    apply_sample(s);
    samples_sent++;
  endtask

  // only called once the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_write(idx, data);
  endtask

  task automatic settle(input int extra_cycles);
    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample(raw_sample(0, 0, 0, 0, 0, 0));
    send_sample(raw_sample(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX));
    // exact center, triggers exactly at both cut-off points
    send_sample(raw_sample(1800, 1800, 1800, 1800, 1250, 2150));
    // deadzone borders fall outside the deadzone
    send_sample(raw_sample(1700, 1900, 1700, 1900, 1251, 2149));
    send_sample(raw_sample(1699, 1901, 1901, 1699, 1700, 1300));
    send_sample(raw_sample(450, 3150, 12'h555, 12'hAAA, 12'hAAA, 12'h555));
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_deadzone_extremes();
    write_reg(REG_CENTER_DZ, '0);
    write_reg(REG_EDGE_DZ, '0);
    send_sample(raw_sample(1800, 1799, 400, 3200, 1200, 2200));
    send_sample(raw_sample(1801, 3200, 399, 0, 1201, 2199));
    settle(SETTLE_CYCLES);
    write_reg(REG_CENTER_DZ, '1);
    send_sample(raw_sample(0, ADC_MAX, 2047, 1, 3000, 10));
    settle(SETTLE_CYCLES);
    write_reg(REG_CENTER_DZ, CFG_DATA_W'(CDZ_RST));
    write_reg(REG_EDGE_DZ, '1);
    send_sample(raw_sample(0, ADC_MAX, 1000, 3000, 0, ADC_MAX));
    settle(SETTLE_CYCLES);
    write_reg(REG_EDGE_DZ, CFG_DATA_W'(EDZ_RST));
    write_reg(REG_UNUSED, '1);
    write_reg(REG_CALIBRATING, 12'hFFE);   // bit 0 clear: stays in normal mode
    send_sample(raw_sample(1000, 2600, 3000, 500, 1500, 1800));
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_capture_widen();
    write_reg(REG_CALIBRATING, 12'd1);
    write_reg(REG_CALIBRATING, 12'h801);
    // capture alone leaves every span empty
    send_sample(raw_sample(2048, 2048, 2048, 2048, 2048, 2048));
    settle(SETTLE_CYCLES);
    write_reg(REG_CALIBRATING, '0);
    send_sample(raw_sample(0, ADC_MAX, 2048, 2100, 0, ADC_MAX));
    settle(SETTLE_CYCLES);
    write_reg(REG_CALIBRATING, 12'd1);
    send_sample(raw_sample(2000, 2100, 1900, 2050, 300, 3800));
    send_sample(raw_sample(200, 3900, 300, 3700, 100, 3000));
    send_sample(raw_sample(3800, 150, 3950, 250, 2000, 4000));
    send_sample(raw_sample(1000, 1000, 1000, 1000, 150, 3950));
    settle(SETTLE_CYCLES);
    write_reg(REG_CALIBRATING, '0);
    write_reg(REG_CALIBRATING, '0);
    send_sample(raw_sample(200, 3900, 250, 3950, 150, 4000));
    send_sample(raw_sample(2000, 2100, 1900, 2050, 350, 3950));
    send_sample(raw_sample(ADC_MAX, 0, 0, ADC_MAX, 0, ADC_MAX));
    settle(SETTLE_CYCLES);
  endtask

  // results held off long enough that the engine backs up into in_bus
  task automatic test_result_backpressure();
    hold_cycles = LONG_HOLD;
    repeat (8) send_sample(random_normal_sample());
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (4) send_sample(random_normal_sample());
      settle(0);
    end
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_random_sessions();
    int unsigned start_count;
    logic [CFG_DATA_W-1:0] mode_word;
    sample_t s;
    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_SAMPLES) begin
      idle_on = (samples_sent - start_count) < RANDOM_SAMPLES - CALM_TAIL;
      settle(SETTLE_CYCLES);
      case ($urandom_range(0, 7))
        0: begin
          write_reg(REG_CENTER_DZ, CFG_DATA_W'($urandom_range(0, ADC_MAX)));
          write_reg(REG_EDGE_DZ, CFG_DATA_W'($urandom_range(0, ADC_MAX)));
        end
        1: begin
          write_reg(REG_CENTER_DZ, $urandom_range(0, 1) ? 12'd0 : 12'hFFF);
          write_reg(REG_EDGE_DZ, $urandom_range(0, 1) ? 12'd0 : 12'hFFF);
        end
        default: begin
          write_reg(REG_CENTER_DZ, CFG_DATA_W'($urandom_range(0, 300)));
          write_reg(REG_EDGE_DZ, CFG_DATA_W'($urandom_range(0, 200)));
        end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        mode_word    = CFG_DATA_W'($urandom_range(0, ADC_MAX));
        mode_word[0] = 1'b1;
        write_reg(REG_CALIBRATING, mode_word);
        for (int i = 0; i < N_AXES; i++)
          s[i] = (i < N_STICK) ? to_raw(1400 + int'($urandom_range(0, 1300)))
                               : ADC_BITS'($urandom_range(0, ADC_MAX));
        send_sample(s);
        repeat ($urandom_range(0, 8)) begin
          for (int i = 0; i < N_AXES; i++)
            case ($urandom_range(0, 2))
              0: s[i] = ADC_BITS'($urandom_range(0, 1600));
              1: s[i] = ADC_BITS'($urandom_range(2500, ADC_MAX));
              default: s[i] = ADC_BITS'($urandom_range(0, ADC_MAX));
            endcase
          send_sample(s);
        end
        settle(SETTLE_CYCLES);
        mode_word    = CFG_DATA_W'($urandom_range(0, ADC_MAX));
        mode_word[0] = 1'b0;
        write_reg(REG_CALIBRATING, mode_word);
      end else if ($urandom_range(0, 2) == 0) begin
        // armed then dropped with no sample: capture stays pending
        write_reg(REG_CALIBRATING, 12'd1);
        write_reg(REG_CALIBRATING, '0);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, ADC_MAX)));
      repeat ($urandom_range(8, 30)) send_sample(random_normal_sample());
    end
    settle(SETTLE_CYCLES);
  endtask

  initial begin : out_ready_drive
    int unsigned gap;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_bus.ready <= 1'b0;
        gap = hold_cycles;
        hold_cycles = 0;
        repeat (gap) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    axes_word_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.right_trigger_out, out_bus.left_trigger_out, out_bus.right_y_out,
             out_bus.right_x_out, out_bus.left_y_out, out_bus.left_x_out};
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        for (int i = 0; i < N_AXES; i++)
          if (got[i] !== want[i]) begin
            $error("%s: expected 0x%04h, actual 0x%04h", field_name[i], want[i], got[i]);
            mismatches++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gamepad_axis_calibrator verification failed");
      $finish;
    end
  end

  initial begin
    rst_n                    = 1'b0;
    in_bus.valid             = 1'b0;
    in_bus.left_x_raw        = '0;
    in_bus.left_y_raw        = '0;
    in_bus.right_x_raw       = '0;
    in_bus.right_y_raw       = '0;
    in_bus.left_trigger_raw  = '0;
    in_bus.right_trigger_raw = '0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = '0;
    cfg_bus.data             = '0;
    load_defaults();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_deadzone_extremes();
    test_capture_widen();
    test_result_backpressure();
    test_sender_pause();
    test_random_sessions();

    if (mismatches == 0) begin
      $display("gamepad_axis_calibrator verification clean");
    end else begin
      $display("gamepad_axis_calibrator verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/gac_pkg.sv
rtl/core/gac_if.sv
rtl/core/gamepad_axis_calibrator.sv
tb/gamepad_axis_calibrator_tb.sv
